// File: rtl/core/gbk_pkg.sv
`timescale 1ns / 1ps

package gbk_pkg;

  localparam int KEY_W            = 5;
  localparam int PAYLOAD_W        = 16;
  localparam int TDATA_W          = 24;
  localparam int MAX_ITEMS_DEF    = 64;
  localparam int KEY_VALUES_DEF   = 32;
  localparam int PAYLOAD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  typedef struct packed {
    logic drop;
    logic last;
  } item_flags_t;

endpackage

// File: rtl/core/gbk_ram.sv
`timescale 1ns / 1ps

module gbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/gbk_front.sv
`timescale 1ns / 1ps

module gbk_front
  import gbk_pkg::*;
#(
  parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
  parameter int KEY_VALUES   = KEY_VALUES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [KEY_W-1:0]        in_key,
  input  logic [PAYLOAD_W-1:0]    in_payload,
  input  logic                    in_last,
  output logic                    q_valid,
  input  logic                    q_ready,
  output logic [KEY_W-1:0]        q_key,
  output logic [PAYLOAD_BITS-1:0] q_payload,
  output item_flags_t             q_flags
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PW_X  = (PAYLOAD_BITS > PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int Q_AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [KEY_W-1:0]        key_sat;
  logic [PW_X-1:0]         pay_x;
  item_flags_t             flags_in;
  logic                    push, pop;

  logic [KEY_W-1:0]        qk_r [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] qp_r [QUEUE_DEPTH];
  item_flags_t             qf_r [QUEUE_DEPTH];
  logic [Q_AW-1:0]         wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0]         qc_r, qc_nxt;

  always_comb begin
    if (32'(in_key) >= KEY_VALUES) begin
      key_sat = KEY_W'(KEY_VALUES - 1);
    end else begin
      key_sat = in_key;
    end
    pay_x         = PW_X'(in_payload);
    flags_in.drop = (fill_r == CNT_W'(MAX_ITEMS));
    flags_in.last = in_last;
  end

  assign in_tready = (qc_r != QC_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (qc_r != '0);
  assign pop       = q_valid && q_ready;
  assign q_key     = qk_r[rp_r];
  assign q_payload = qp_r[rp_r];
  assign q_flags   = qf_r[rp_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push) begin
      if (in_last) begin
        fill_nxt = '0;
      end else if (!flags_in.drop) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) begin
      wp_nxt = (wp_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + Q_AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + Q_AW'(1);
    end
    qc_nxt = qc_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      qc_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      qc_r   <= qc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qk_r[wp_r] <= key_sat;
      qp_r[wp_r] <= pay_x[PAYLOAD_BITS-1:0];
      qf_r[wp_r] <= flags_in;
    end
  end

endmodule

// File: rtl/core/gbk_back.sv
`timescale 1ns / 1ps

module gbk_back
  import gbk_pkg::*;
#(
  parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
  parameter int KEY_VALUES   = KEY_VALUES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [KEY_W-1:0]        q_key,
  input  logic [PAYLOAD_BITS-1:0] q_payload,
  input  item_flags_t             q_flags,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [TDATA_W-1:0]      out_tdata,
  output logic                    out_tlast,
  output logic                    out_tuser
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SLOT_W = $clog2(MAX_ITEMS);
  localparam int KIDX_W = $clog2(KEY_VALUES);
  localparam int KX_W   = (KIDX_W > KEY_W) ? KIDX_W : KEY_W;
  localparam int PW_X   = (PAYLOAD_BITS > PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int REC_W  = KEY_W + PAYLOAD_BITS;
  localparam int KM_W   = CNT_W + SLOT_W;

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_UPD     = 4'd1;
  localparam logic [3:0] ST_PFX_RD  = 4'd2;
  localparam logic [3:0] ST_PFX_WR  = 4'd3;
  localparam logic [3:0] ST_SW_FROM = 4'd4;
  localparam logic [3:0] ST_SW_SRC  = 4'd5;
  localparam logic [3:0] ST_SW_REC  = 4'd6;
  localparam logic [3:0] ST_SW_DST  = 4'd7;
  localparam logic [3:0] ST_SW_WA   = 4'd8;
  localparam logic [3:0] ST_SW_WB   = 4'd9;
  localparam logic [3:0] ST_EM_RD   = 4'd10;
  localparam logic [3:0] ST_EM_WT   = 4'd11;

  logic [3:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [KEY_VALUES-1:0]   kvalid_r, kvalid_nxt;
  logic [KEY_VALUES-1:0]   open_r, open_nxt;
  logic [KIDX_W-1:0]       k_r, k_nxt;
  logic [CNT_W-1:0]        off_r, off_nxt;
  logic [KIDX_W-1:0]       from_r, from_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [SLOT_W-1:0]       src_r, src_nxt;
  logic [SLOT_W-1:0]       dst_r, dst_nxt;
  logic [KIDX_W-1:0]       to_r, to_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]       i_r, i_nxt;

  logic [REC_W-1:0]        rec_a_r, rec_a_nxt;
  logic [KEY_W-1:0]        ld_key_r, ld_key_nxt;
  logic [PAYLOAD_BITS-1:0] ld_pay_r, ld_pay_nxt;
  logic                    ld_last_r, ld_last_nxt;

  logic                    ov_r, ov_nxt;
  logic [TDATA_W-1:0]      od_r, od_nxt;
  logic                    ol_r, ol_nxt;
  logic                    ou_r, ou_nxt;

  logic                    st_we, st_re, km_we, km_re;
  logic [SLOT_W-1:0]       st_waddr, st_raddr;
  logic [REC_W-1:0]        st_wdata, st_rdata;
  logic [KIDX_W-1:0]       km_waddr, km_raddr;
  logic [KM_W-1:0]         km_wdata, km_rdata;

  logic [CNT_W-1:0]        kd_cnt, kd_cnt_v, cnt_dec;
  logic [SLOT_W-1:0]       kd_off;
  logic [KX_W-1:0]         ld_key_x, q_key_x, rec_key_x;
  logic [KIDX_W-1:0]       ld_idx, q_idx, rec_idx;
  logic [KEY_W-1:0]        em_key;
  logic [PW_X-1:0]         em_pay_x;
  logic                    em_last;

  gbk_ram #(.WIDTH(REC_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  gbk_ram #(.WIDTH(KM_W), .DEPTH(KEY_VALUES)) u_keymem (
    .clk   (clk),
    .we    (km_we),
    .waddr (km_waddr),
    .wdata (km_wdata),
    .re    (km_re),
    .raddr (km_raddr),
    .rdata (km_rdata)
  );

  always_comb begin
    kd_cnt    = km_rdata[KM_W-1 -: CNT_W];
    kd_off    = km_rdata[SLOT_W-1:0];
    cnt_dec   = cnt_r - CNT_W'(1);
    ld_key_x  = KX_W'(ld_key_r);
    ld_idx    = ld_key_x[KIDX_W-1:0];
    q_key_x   = KX_W'(q_key);
    q_idx     = q_key_x[KIDX_W-1:0];
    rec_key_x = KX_W'(st_rdata[REC_W-1 -: KEY_W]);
    rec_idx   = rec_key_x[KIDX_W-1:0];
    em_key    = st_rdata[REC_W-1 -: KEY_W];
    em_pay_x  = PW_X'(st_rdata[PAYLOAD_BITS-1:0]);
    em_last   = (CNT_W'(i_r) + CNT_W'(1) == n_r);
  end

  assign kd_cnt_v = (state_r == ST_UPD) ? (kvalid_r[ld_idx] ? kd_cnt : '0)
                                        : (kvalid_r[k_r] ? kd_cnt : '0);

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    ovf_nxt     = ovf_r;
    kvalid_nxt  = kvalid_r;
    open_nxt    = open_r;
    k_nxt       = k_r;
    off_nxt     = off_r;
    from_nxt    = from_r;
    rem_nxt     = rem_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    to_nxt      = to_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    rec_a_nxt   = rec_a_r;
    ld_key_nxt  = ld_key_r;
    ld_pay_nxt  = ld_pay_r;
    ld_last_nxt = ld_last_r;
    ov_nxt      = ov_r && !out_tready;
    od_nxt      = od_r;
    ol_nxt      = ol_r;
    ou_nxt      = ou_r;

    q_ready  = 1'b0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = '0;
    st_re    = 1'b0;
    st_raddr = '0;
    km_we    = 1'b0;
    km_waddr = '0;
    km_wdata = '0;
    km_re    = 1'b0;
    km_raddr = '0;

    case (state_r)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          ld_key_nxt  = q_key;
          ld_pay_nxt  = q_payload;
          ld_last_nxt = q_flags.last;
          if (q_flags.drop) begin
            ovf_nxt = 1'b1;
            if (q_flags.last) begin
              k_nxt     = '0;
              off_nxt   = '0;
              state_nxt = ST_PFX_RD;
            end
          end else begin
            km_re     = 1'b1;
            km_raddr  = q_idx;
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        km_we              = 1'b1;
        km_waddr           = ld_idx;
        km_wdata           = {kd_cnt_v + CNT_W'(1), SLOT_W'(0)};
        kvalid_nxt[ld_idx] = 1'b1;
        st_we              = 1'b1;
        st_waddr           = n_r[SLOT_W-1:0];
        st_wdata           = {ld_key_r, ld_pay_r};
        n_nxt              = n_r + CNT_W'(1);
        if (ld_last_r) begin
          k_nxt     = '0;
          off_nxt   = '0;
          state_nxt = ST_PFX_RD;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_PFX_RD: begin
        km_re     = 1'b1;
        km_raddr  = k_r;
        state_nxt = ST_PFX_WR;
      end
      ST_PFX_WR: begin
        km_we           = 1'b1;
        km_waddr        = k_r;
        km_wdata        = {kd_cnt_v, off_r[SLOT_W-1:0]};
        kvalid_nxt[k_r] = 1'b1;
        open_nxt[k_r]   = (kd_cnt_v != '0);
        off_nxt         = off_r + kd_cnt_v;
        if (k_r == KIDX_W'(KEY_VALUES - 1)) begin
          rem_nxt   = n_r;
          from_nxt  = '0;
          state_nxt = ST_SW_FROM;
        end else begin
          k_nxt     = k_r + KIDX_W'(1);
          state_nxt = ST_PFX_RD;
        end
      end
      ST_SW_FROM: begin
        if (rem_r == '0) begin
          i_nxt     = '0;
          state_nxt = ST_EM_RD;
        end else if (!open_r[from_r]) begin
          if (from_r == KIDX_W'(KEY_VALUES - 1)) begin
            i_nxt     = '0;
            state_nxt = ST_EM_RD;
          end else begin
            from_nxt = from_r + KIDX_W'(1);
          end
        end else begin
          km_re     = 1'b1;
          km_raddr  = from_r;
          state_nxt = ST_SW_SRC;
        end
      end
      ST_SW_SRC: begin
        src_nxt   = kd_off;
        st_re     = 1'b1;
        st_raddr  = kd_off;
        state_nxt = ST_SW_REC;
      end
      ST_SW_REC: begin
        rec_a_nxt = st_rdata;
        to_nxt    = rec_idx;
        if (!open_r[rec_idx]) begin
          i_nxt     = '0;
          state_nxt = ST_EM_RD;
        end else begin
          km_re     = 1'b1;
          km_raddr  = rec_idx;
          state_nxt = ST_SW_DST;
        end
      end
      ST_SW_DST: begin
        dst_nxt   = kd_off;
        cnt_nxt   = kd_cnt;
        st_re     = 1'b1;
        st_raddr  = kd_off;
        state_nxt = ST_SW_WA;
      end
      ST_SW_WA: begin
        st_we    = 1'b1;
        st_waddr = src_r;
        st_wdata = st_rdata;
        km_we    = 1'b1;
        km_waddr = to_r;
        if (cnt_dec != '0) begin
          km_wdata = {cnt_dec, dst_r + SLOT_W'(1)};
        end else begin
          km_wdata       = {cnt_dec, dst_r};
          open_nxt[to_r] = 1'b0;
        end
        state_nxt = ST_SW_WB;
      end
      ST_SW_WB: begin
        st_we     = 1'b1;
        st_waddr  = dst_r;
        st_wdata  = rec_a_r;
        rem_nxt   = rem_r - CNT_W'(1);
        state_nxt = ST_SW_FROM;
      end
      ST_EM_RD: begin
        if (n_r == '0) begin
          ovf_nxt    = 1'b0;
          kvalid_nxt = '0;
          open_nxt   = '0;
          state_nxt  = ST_LOAD;
        end else begin
          st_re     = 1'b1;
          st_raddr  = i_r;
          state_nxt = ST_EM_WT;
        end
      end
      ST_EM_WT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = TDATA_W'({em_pay_x[PAYLOAD_W-1:0], em_key});
          ol_nxt = em_last;
          ou_nxt = ovf_r;
          if (em_last) begin
            n_nxt      = '0;
            ovf_nxt    = 1'b0;
            kvalid_nxt = '0;
            open_nxt   = '0;
            state_nxt  = ST_LOAD;
          end else begin
            i_nxt     = i_r + SLOT_W'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      n_r      <= '0;
      ovf_r    <= 1'b0;
      kvalid_r <= '0;
      open_r   <= '0;
      k_r      <= '0;
      off_r    <= '0;
      from_r   <= '0;
      rem_r    <= '0;
      i_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      ovf_r    <= ovf_nxt;
      kvalid_r <= kvalid_nxt;
      open_r   <= open_nxt;
      k_r      <= k_nxt;
      off_r    <= off_nxt;
      from_r   <= from_nxt;
      rem_r    <= rem_nxt;
      i_r      <= i_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    to_r      <= to_nxt;
    cnt_r     <= cnt_nxt;
    rec_a_r   <= rec_a_nxt;
    ld_key_r  <= ld_key_nxt;
    ld_pay_r  <= ld_pay_nxt;
    ld_last_r <= ld_last_nxt;
    od_r      <= od_nxt;
    ol_r      <= ol_nxt;
    ou_r      <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule

// File: rtl/core/group_records_by_key_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                          Contents
// in_      slave      tvalid tready tdata tlast      tdata: key, payload; tlast: last_item
// out_     master     tvalid tready tdata tlast tuser tdata: key_res, payload_res;
//                                                    tlast: last_result; tuser: overflowed
//
// Each stored record is loaded via a load state and a count read-modify-write state.
// The last record starts a pass over every key value for the key offsets, then a swap
// pass through the from, src, rec, dst, wa and wb states per record, plus key scanning.
// Records are emitted via a read and a wait state; the output register holds under stall.
// Reset is synchronous and active low; stored records are not cleared.
// A two-entry queue keeps accepting input while the set is processed, until it is full.

module group_records_by_key_top
  import gbk_pkg::*;
#(
  parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
  parameter int KEY_VALUES   = KEY_VALUES_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // key [4:0], payload [20:5]
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // key_res [4:0], payload_res [20:5]
  output logic               out_tlast,
  output logic               out_tuser   // overflowed [0]
);

  logic                    q_valid;
  logic                    q_ready;
  logic [KEY_W-1:0]        q_key;
  logic [PAYLOAD_BITS-1:0] q_payload;
  item_flags_t             q_flags;

  gbk_front #(
    .MAX_ITEMS    (MAX_ITEMS),
    .KEY_VALUES   (KEY_VALUES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_payload (in_tdata[KEY_W+PAYLOAD_W-1:KEY_W]),
    .in_last    (in_tlast),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_key      (q_key),
    .q_payload  (q_payload),
    .q_flags    (q_flags)
  );

  gbk_back #(
    .MAX_ITEMS    (MAX_ITEMS),
    .KEY_VALUES   (KEY_VALUES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_key      (q_key),
    .q_payload  (q_payload),
    .q_flags    (q_flags),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
